// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; every user has clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rdqt_pkg.sv =====
// ----------------------------------------------------------------------------
// rdqt_pkg
// Shared constants and helpers of the read N/quality trimmer.
// ----------------------------------------------------------------------------
package rdqt_pkg;

    localparam int DEF_MAX_READ_LEN = 512;
    localparam int CHAR_W           = 8;
    localparam int QUAL_W           = 8;
    localparam int WIN_W            = 10;   // window ports and min_good_run
    localparam int CFG_W            = 10;   // widest config register
    localparam int CFG_IDX_W        = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_CUTOFF = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GOOD_RUN   = 1'd1;

    localparam logic [QUAL_W-1:0] RST_QUALITY_CUTOFF = 8'd0;
    localparam logic [WIN_W-1:0]  RST_MIN_GOOD_RUN   = 10'd16;

    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C     = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G     = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_N     = 8'h4E;
    localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

    function automatic logic is_acgt(input logic [CHAR_W-1:0] ch);
        is_acgt = (ch == CHAR_A) || (ch == CHAR_C) || (ch == CHAR_G) || (ch == CHAR_T);
    endfunction

endpackage

// ===== hdl/rdqt_qwin.sv =====
// ----------------------------------------------------------------------------
// rdqt_qwin
// Low-quality flag memory and the serial quality-window scan over it.
// ----------------------------------------------------------------------------
module rdqt_qwin #(
    parameter int MAX_READ_LEN = rdqt_pkg::DEF_MAX_READ_LEN,
    parameter int POS_W        = $clog2(MAX_READ_LEN + 1),
    parameter int AW           = $clog2(MAX_READ_LEN)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // flag write port, one per stored base
    input  logic                        flag_we,
    input  logic [AW-1:0]               flag_addr,
    input  logic                        flag_data,
    // scan request
    input  logic                        scan_go,
    input  logic [POS_W-1:0]            scan_len,
    input  logic [POS_W-1:0]            scan_start,
    input  logic [rdqt_pkg::WIN_W-1:0]  scan_min,
    // scan result
    output logic                        scan_done,
    output logic [POS_W-1:0]            good_lo,
    output logic [POS_W-1:0]            good_hi
);
    import rdqt_pkg::*;

    localparam int CMP_W = (POS_W > WIN_W) ? POS_W : WIN_W;

    logic                flag_mem [MAX_READ_LEN];
    logic                rd_flag_reg;

    logic                run_reg,  run_next;
    logic                pvld_reg, pvld_next;
    logic [POS_W-1:0]    issue_reg, issue_next;
    logic [POS_W-1:0]    pidx_reg,  pidx_next;
    logic [POS_W-1:0]    len_reg,   len_next;
    logic [POS_W-1:0]    cs_reg,    cs_next;
    logic [POS_W-1:0]    q0_reg,    q0_next;
    logic [POS_W-1:0]    q1_reg,    q1_next;
    logic [CMP_W-1:0]    best_reg,  best_next;
    logic                done_reg,  done_next;

    logic                issuing;
    logic                take;
    logic [POS_W-1:0]    run_len;
    logic [POS_W-1:0]    tail_len;

    // flag memory: one write port from intake, one registered read for the scan
    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_addr] <= flag_data;
        end
        rd_flag_reg <= flag_mem[issue_reg[AW-1:0]];
    end

    assign issuing  = run_reg && (issue_reg < len_reg);
    assign run_len  = pidx_reg - cs_reg;
    assign take     = pvld_reg && rd_flag_reg
                      && (pidx_reg >= q0_reg) && (pidx_reg < q1_reg);
    assign tail_len = len_reg - cs_reg;

    always_comb
    begin
        run_next   = run_reg;
        pvld_next  = issuing;
        issue_next = issue_reg;
        pidx_next  = issue_reg;
        len_next   = len_reg;
        cs_next    = cs_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        best_next  = best_reg;
        done_next  = 1'b0;

        if (scan_go)
        begin
            run_next   = 1'b1;
            pvld_next  = 1'b0;
            issue_next = '0;
            len_next   = scan_len;
            cs_next    = scan_start;
            q0_next    = '0;
            q1_next    = scan_len;
            best_next  = CMP_W'(scan_min);
        end
        else if (run_reg)
        begin
            if (issuing)
            begin
                issue_next = issue_reg + POS_W'(1);
            end
            // low-quality base inside the window as updated so far
            if (take)
            begin
                if ((pidx_reg >= cs_reg) && (CMP_W'(run_len) > best_reg))
                begin
                    q0_next   = cs_reg;
                    q1_next   = pidx_reg;
                    best_next = CMP_W'(run_len);
                end
                cs_next = pidx_reg + POS_W'(1);
            end
            // all flags read and processed: trailing run check
            if (!issuing && !pvld_reg)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                if (CMP_W'(tail_len) > best_reg)
                begin
                    q0_next = cs_reg;
                    q1_next = len_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            pvld_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            pvld_reg <= pvld_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg <= issue_next;
        pidx_reg  <= pidx_next;
        len_reg   <= len_next;
        cs_reg    <= cs_next;
        q0_reg    <= q0_next;
        q1_reg    <= q1_next;
        best_reg  <= best_next;
    end

    assign scan_done = done_reg;
    assign good_lo   = q0_reg;
    assign good_hi   = q1_reg;

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_go_when_idle, scan_go, !run_reg, "scan request while scan running")
    `ASSERT_NEXT(a_done_stops, done_reg, !run_reg && !pvld_reg, "scan active after done")
    `ASSERT_IMPLY(a_issue_bound, run_reg, issue_reg <= len_reg, "scan read past read length")

endmodule

// ===== hdl/read_n_and_quality_trimmer.sv =====
// ----------------------------------------------------------------------------
// read_n_and_quality_trimmer
// Masks low-quality bases of a read, finds its longest N-free window and
// its quality-trimmed window.
// ----------------------------------------------------------------------------
// Timing: a non-final base gives its result in the cycle after its accepting
//   edge, and a new base is taken every cycle while busy is low; the final base
//   holds busy through PREP and the quality scan and gives its result once the
//   serial scan, which reads one stored flag per cycle from the flag memory,
//   has finished.
// Reset: asynchronous, active low; clears control and per-read state (not ns_reg
//   and ne_reg) and loads the config defaults. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module read_n_and_quality_trimmer #(
    parameter int MAX_READ_LEN = rdqt_pkg::DEF_MAX_READ_LEN
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write port
    input  logic                            cfg_we,
    input  logic [rdqt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rdqt_pkg::CFG_W-1:0]      cfg_data,
    // command side
    input  logic                            start,
    output logic                            busy,
    input  logic [rdqt_pkg::CHAR_W-1:0]     base_char,
    input  logic [rdqt_pkg::QUAL_W-1:0]     quality_score,
    input  logic                            last_base,
    // result side, one-cycle strobe
    output logic                            valid,
    output logic [rdqt_pkg::CHAR_W-1:0]     masked_base,
    output logic                            read_done,
    output logic [rdqt_pkg::WIN_W-1:0]      n_free_start,
    output logic [rdqt_pkg::WIN_W-1:0]      n_free_end,
    output logic [rdqt_pkg::WIN_W-1:0]      good_start,
    output logic [rdqt_pkg::WIN_W-1:0]      good_end,
    output logic                            any_flaw
);
    import rdqt_pkg::*;

    localparam int POS_W = $clog2(MAX_READ_LEN + 1);
    localparam int AW    = $clog2(MAX_READ_LEN);

    localparam logic [1:0] ST_IDLE = 2'd0;   // taking bases
    localparam logic [1:0] ST_PREP = 2'd1;   // settle N window, launch scan
    localparam logic [1:0] ST_WAIT = 2'd2;   // quality scan running

    // config registers
    logic [QUAL_W-1:0]  cutoff_reg;
    logic [WIN_W-1:0]   min_run_reg;

    logic [1:0]         state_reg, state_next;

    // per-read state
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [POS_W-1:0]   run_start_reg, run_start_next;
    logic [POS_W-1:0]   best_len_reg,  best_len_next;
    logic [POS_W-1:0]   best_start_reg, best_start_next;
    logic [POS_W-1:0]   best_end_reg,  best_end_next;
    logic               flaw_reg,      flaw_next;
    logic [POS_W-1:0]   ns_reg,        ns_next;
    logic [POS_W-1:0]   ne_reg,        ne_next;

    // result registers
    logic               valid_reg,     valid_next;
    logic [CHAR_W-1:0]  masked_reg,    masked_next;
    logic               done_reg,      done_next;
    logic [WIN_W-1:0]   nfs_reg,       nfs_next;
    logic [WIN_W-1:0]   nfe_reg,       nfe_next;
    logic [WIN_W-1:0]   gs_reg,        gs_next;
    logic [WIN_W-1:0]   ge_reg,        ge_next;
    logic               flaw_out_reg,  flaw_out_next;

    logic               accept;
    logic               low_q;
    logic               is_n;
    logic               in_range;
    logic [POS_W-1:0]   cur_len;
    logic [POS_W-1:0]   tail_len;
    logic               scan_go;
    logic               scan_done;
    logic [POS_W-1:0]   good_lo;
    logic [POS_W-1:0]   good_hi;

    assign accept   = start && (state_reg == ST_IDLE);
    assign low_q    = quality_score < cutoff_reg;
    assign is_n     = base_char == CHAR_N;
    // bases past the maximum length are masked but not stored or counted
    assign in_range = pos_reg < POS_W'(MAX_READ_LEN);
    assign cur_len  = pos_reg - run_start_reg;
    assign tail_len = pos_reg - run_start_reg;
    assign scan_go  = state_reg == ST_PREP;

    // ---------------- config port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg  <= RST_QUALITY_CUTOFF;
            min_run_reg <= RST_MIN_GOOD_RUN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUALITY_CUTOFF: cutoff_reg  <= cfg_data[QUAL_W-1:0];
                CFG_MIN_GOOD_RUN:   min_run_reg <= cfg_data[WIN_W-1:0];
                default:            ;
            endcase
        end
    end

    // ---------------- control and per-read state ----------------
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        run_start_next  = run_start_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        best_end_next   = best_end_reg;
        flaw_next       = flaw_reg;
        ns_next         = ns_reg;
        ne_next         = ne_reg;

        valid_next      = 1'b0;
        masked_next     = masked_reg;
        done_next       = done_reg;
        nfs_next        = nfs_reg;
        nfe_next        = nfe_reg;
        gs_next         = gs_reg;
        ge_next         = ge_reg;
        flaw_out_next   = flaw_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    masked_next = (low_q && is_acgt(base_char))
                                  ? base_char + CASE_DELTA : base_char;
                    flaw_next   = flaw_reg || low_q || is_n;
                    if (in_range)
                    begin
                        // an N closes the current N-free run
                        if (is_n)
                        begin
                            if (cur_len > best_len_reg)
                            begin
                                best_start_next = run_start_reg;
                                best_end_next   = pos_reg;
                                best_len_next   = cur_len;
                            end
                            run_start_next = pos_reg + POS_W'(1);
                        end
                        pos_next = pos_reg + POS_W'(1);
                    end
                    if (last_base)
                    begin
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        // mid-read transfer: window fields read as zero
                        valid_next    = 1'b1;
                        done_next     = 1'b0;
                        nfs_next      = '0;
                        nfe_next      = '0;
                        gs_next       = '0;
                        ge_next       = '0;
                        flaw_out_next = 1'b0;
                    end
                end
            end
            ST_PREP:
            begin
                // no run beat zero: window spans the read unless the tail wins
                ns_next = best_start_reg;
                ne_next = (best_len_reg == '0) ? pos_reg : best_end_reg;
                if (tail_len > best_len_reg)
                begin
                    ns_next = run_start_reg;
                    ne_next = pos_reg;
                end
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (scan_done)
                begin
                    valid_next      = 1'b1;
                    done_next       = 1'b1;
                    nfs_next        = WIN_W'(ns_reg);
                    nfe_next        = WIN_W'(ne_reg);
                    gs_next         = WIN_W'(good_lo);
                    ge_next         = WIN_W'(good_hi);
                    flaw_out_next   = flaw_reg;
                    // ready for the next read
                    pos_next        = '0;
                    run_start_next  = '0;
                    best_len_next   = '0;
                    best_start_next = '0;
                    best_end_next   = '0;
                    flaw_next       = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            run_start_reg  <= '0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
            best_end_reg   <= '0;
            flaw_reg       <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            run_start_reg  <= run_start_next;
            best_len_reg   <= best_len_next;
            best_start_reg <= best_start_next;
            best_end_reg   <= best_end_next;
            flaw_reg       <= flaw_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ns_reg       <= ns_next;
        ne_reg       <= ne_next;
        masked_reg   <= masked_next;
        done_reg     <= done_next;
        nfs_reg      <= nfs_next;
        nfe_reg      <= nfe_next;
        gs_reg       <= gs_next;
        ge_reg       <= ge_next;
        flaw_out_reg <= flaw_out_next;
    end

    // ---------------- flag memory and quality scan ----------------
    rdqt_qwin #(
        .MAX_READ_LEN (MAX_READ_LEN),
        .POS_W        (POS_W),
        .AW           (AW)
    ) u_qwin (
        .clk        (clk),
        .rst_n      (rst_n),
        .flag_we    (accept && in_range),
        .flag_addr  (pos_reg[AW-1:0]),
        .flag_data  (low_q),
        .scan_go    (scan_go),
        .scan_len   (pos_reg),
        .scan_start (ns_next),
        .scan_min   (min_run_reg),
        .scan_done  (scan_done),
        .good_lo    (good_lo),
        .good_hi    (good_hi)
    );

    // The scan latches its start on the edge that leaves PREP, the same edge
    // that loads ns_reg, so it takes the N window start straight from PREP.

    assign busy         = state_reg != ST_IDLE;
    assign valid        = valid_reg;
    assign masked_base  = masked_reg;
    assign read_done    = done_reg;
    assign n_free_start = nfs_reg;
    assign n_free_end   = nfe_reg;
    assign good_start   = gs_reg;
    assign good_end     = ge_reg;
    assign any_flaw     = flaw_out_reg;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_mid_read_result, start && !busy && !last_base, valid && !read_done, "mid-read base gave no transfer")
    `ASSERT_NEXT(a_last_goes_busy, start && !busy && last_base, busy && !valid, "final base did not start the scan")
    `ASSERT_ALWAYS(a_pos_bound, pos_reg <= POS_W'(MAX_READ_LEN), "read position past maximum")
    `ASSERT_IMPLY(a_done_pairs_wait, scan_done, state_reg == ST_WAIT, "scan finished outside wait")

endmodule
